// ===== hw/rtl/kmse_pkg.sv =====
package kmse_pkg;

    localparam int unsigned NUM_ROWS = 8;

    localparam logic [7:0] USAGE_ESC    = 8'h29;
    localparam logic [7:0] USAGE_TILDE  = 8'h35;
    localparam logic [7:0] USAGE_LSHIFT = 8'hE1;
    localparam logic [7:0] USAGE_RSHIFT = 8'hE5;

    localparam logic [2:0] LAST_COLUMN = 3'd7;
    localparam logic [2:0] LAYER_ROW   = 3'd6;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_COMMIT  = 2'd2
    } kmse_kind_t;

    // per-row result of one lane
    typedef struct packed {
        logic       chg;
        logic       down;
        logic [7:0] code;
    } kmse_lane_t;

    // key slot for each matrix position, index {row, column}
    localparam logic [5:0] SLOT_TBL [0:63] = '{
        6'd23, 6'd0,  6'd20, 6'd24, 6'd15, 6'd19, 6'd16, 6'd0,
        6'd50, 6'd52, 6'd49, 6'd51, 6'd43, 6'd46, 6'd45, 6'd41,
        6'd36, 6'd27, 6'd48, 6'd39, 6'd30, 6'd33, 6'd44, 6'd28,
        6'd58, 6'd60, 6'd57, 6'd59, 6'd55, 6'd47, 6'd56, 6'd42,
        6'd22, 6'd26, 6'd21, 6'd25, 6'd14, 6'd18, 6'd17, 6'd53,
        6'd37, 6'd40, 6'd35, 6'd38, 6'd31, 6'd34, 6'd32, 6'd29,
        6'd8,  6'd12, 6'd7,  6'd11, 6'd0,  6'd4,  6'd3,  6'd54,
        6'd9,  6'd13, 6'd6,  6'd10, 6'd1,  6'd5,  6'd2,  6'd0
    };

    localparam logic [7:0] USAGE_L0 [0:60] = '{
        8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h2D, 8'h2E, 8'h2A, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18,
        8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09,
        8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'hE1, 8'h1D, 8'h1B,
        8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'hE0, 8'h00,
        8'hE2, 8'h2C, 8'hE6, 8'hE7, 8'hE7, 8'hE4
    };

    localparam logic [7:0] USAGE_L1 [0:60] = '{
        8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43,
        8'h44, 8'h45, 8'h4C, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18,
        8'h49, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09,
        8'h0A, 8'h50, 8'h51, 8'h52, 8'h4F, 8'h33, 8'h34, 8'h28, 8'hE1, 8'h1D, 8'h1B,
        8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'hE0, 8'h00,
        8'hE2, 8'h2C, 8'hE6, 8'hE7, 8'hE7, 8'hE4
    };

endpackage

// ===== hw/rtl/kmse_lane.sv =====
module kmse_lane (
    input  logic [2:0]         row_idx,
    input  logic [2:0]         column,
    input  logic               sense,
    input  logic               was_down,
    input  logic               layer,
    output kmse_pkg::kmse_lane_t res
);

    logic [5:0] slot;
    logic       now_down;

    assign now_down = ~sense;
    assign slot     = kmse_pkg::SLOT_TBL[{row_idx, column}];

    always_comb begin
        res.chg  = now_down ^ was_down;
        res.down = now_down;
        res.code = layer ? kmse_pkg::USAGE_L1[slot] : kmse_pkg::USAGE_L0[slot];
    end

endmodule

// ===== hw/rtl/kmse_merge.sv =====
module kmse_merge (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_load,
    input  kmse_pkg::kmse_lane_t   lanes [kmse_pkg::NUM_ROWS],
    input  logic                   commit_in,
    output logic                   item_ready,
    output logic                   m_valid,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_code,
    output logic                   m_last,
    input  logic                   m_ready
);

    logic [7:0] pend_reg,  pend_next;
    logic [7:0] down_reg,  down_next;
    logic [7:0] code_reg [kmse_pkg::NUM_ROWS];
    logic       commit_reg, commit_next;
    logic       busy_reg,  busy_next;
    logic       tilde_reg, tilde_next;
    logic [1:0] shift_reg, shift_next;
    logic       ov_reg,    ov_next;
    logic [1:0] okind_reg, okind_next;
    logic [7:0] ocode_reg, ocode_next;
    logic       olast_reg, olast_next;

    logic       has_work, out_ok, step, item_done;
    logic [2:0] sel;
    logic [7:0] sel_code, ev_code;
    logic       sel_down, clear_bit, ev_last;
    kmse_pkg::kmse_kind_t ev_kind;
    logic [7:0] mask_after;
    logic [1:0] shift_upd;

    assign has_work = (|pend_reg) | commit_reg;
    assign out_ok   = ~ov_reg | m_ready;
    assign step     = busy_reg & has_work & out_ok;

    // lowest pending row goes first
    always_comb begin
        sel = 3'd0;
        for (int i = kmse_pkg::NUM_ROWS - 1; i >= 0; i--) begin
            if (pend_reg[i]) sel = 3'(i);
        end
    end

    assign sel_code = code_reg[sel];
    assign sel_down = down_reg[sel];

    always_comb begin
        ev_kind   = kmse_pkg::EV_COMMIT;
        ev_code   = 8'h00;
        clear_bit = 1'b0;
        shift_upd = shift_reg;
        if (|pend_reg) begin
            clear_bit = 1'b1;
            if (sel_down) begin
                ev_kind = kmse_pkg::EV_PRESS;
                ev_code = (sel_code == kmse_pkg::USAGE_ESC && shift_reg != 2'b00)
                          ? kmse_pkg::USAGE_TILDE : sel_code;
                if (ev_code == kmse_pkg::USAGE_LSHIFT) shift_upd[0] = 1'b1;
                if (ev_code == kmse_pkg::USAGE_RSHIFT) shift_upd[1] = 1'b1;
            end else begin
                ev_kind = kmse_pkg::EV_RELEASE;
                if (sel_code == kmse_pkg::USAGE_ESC && !tilde_reg) begin
                    // escape release is preceded by a tilde release
                    ev_code   = kmse_pkg::USAGE_TILDE;
                    clear_bit = 1'b0;
                end else begin
                    ev_code = sel_code;
                    if (ev_code == kmse_pkg::USAGE_LSHIFT) shift_upd[0] = 1'b0;
                    if (ev_code == kmse_pkg::USAGE_RSHIFT) shift_upd[1] = 1'b0;
                end
            end
        end
        mask_after = pend_reg;
        if (clear_bit) mask_after[sel] = 1'b0;
        ev_last = (|pend_reg) ? (mask_after == 8'h00 && !commit_reg) : 1'b1;
    end

    assign item_done  = busy_reg & (~has_work | (step & ev_last));
    assign item_ready = ~busy_reg | item_done;

    always_comb begin
        pend_next   = pend_reg;
        down_next   = down_reg;
        commit_next = commit_reg;
        tilde_next  = tilde_reg;
        busy_next   = busy_reg & ~item_done;
        shift_next  = shift_reg;
        if (step) begin
            shift_next = shift_upd;
            if (|pend_reg) begin
                pend_next  = mask_after;
                tilde_next = ~clear_bit;
            end else begin
                commit_next = 1'b0;
            end
        end
        if (item_load) begin
            for (int i = 0; i < kmse_pkg::NUM_ROWS; i++) begin
                pend_next[i] = lanes[i].chg;
                down_next[i] = lanes[i].down;
            end
            commit_next = commit_in;
            tilde_next  = 1'b0;
            busy_next   = 1'b1;
        end
    end

    always_comb begin
        ov_next    = ov_reg & ~m_ready;
        okind_next = okind_reg;
        ocode_next = ocode_reg;
        olast_next = olast_reg;
        if (step) begin
            ov_next    = 1'b1;
            okind_next = ev_kind;
            ocode_next = ev_code;
            olast_next = ev_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            pend_reg   <= '0;
            commit_reg <= 1'b0;
            tilde_reg  <= 1'b0;
            shift_reg  <= '0;
            ov_reg     <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            pend_reg   <= pend_next;
            commit_reg <= commit_next;
            tilde_reg  <= tilde_next;
            shift_reg  <= shift_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        down_reg  <= down_next;
        okind_reg <= okind_next;
        ocode_reg <= ocode_next;
        olast_reg <= olast_next;
        if (item_load) begin
            for (int i = 0; i < kmse_pkg::NUM_ROWS; i++) begin
                code_reg[i] <= lanes[i].code;
            end
        end
    end

    assign m_valid = ov_reg;
    assign m_kind  = okind_reg;
    assign m_code  = ocode_reg;
    assign m_last  = olast_reg;

endmodule

// ===== hw/rtl/keyboard_matrix_scan_events.sv =====
// keyboard matrix scan event generator. each request carries one driven column and its
// eight active-low sense lines; eight row lanes compare them against the 64-key pressed
// map in parallel, look up the usage code (layer taken from row 6 column 7) and the map is
// updated as the request is taken. a merge stage then emits press/release events for the
// changed rows in row order, one event per cycle, with shift-escape giving tilde and an
// escape release preceded by a tilde release; a commit event follows a column 7 request
// when anything changed since the last commit. input flow is set by that single event
// serializer: a request occupies it until it has issued all its events, and a new request
// is taken in the cycle the previous one finishes. events sit in an output register, so
// the last event of a request can wait there while the next request is taken; any longer
// stall on the result side holds the serializer and with it the input.
module keyboard_matrix_scan_events (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] column, [10:3] sense_bits, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] event_kind, [9:2] usage_code, rest zero
    output logic        m_axis_tlast
);

    logic [7:0] map_reg [kmse_pkg::NUM_ROWS];   // map_reg[row][column], 1 = pressed
    logic [7:0] map_next [kmse_pkg::NUM_ROWS];
    logic       scan_changed_reg, scan_changed_next;

    logic [2:0] column;
    logic [7:0] sense_bits;
    logic       s_accept, item_ready, any_chg, commit;
    logic [1:0] m_kind;
    logic [7:0] m_code;

    kmse_pkg::kmse_lane_t lanes [kmse_pkg::NUM_ROWS];

    assign column     = s_axis_tdata[2:0];
    assign sense_bits = s_axis_tdata[10:3];
    assign s_axis_tready = item_ready;
    assign s_accept   = s_axis_tvalid & item_ready;

    // one lane per row
    for (genvar r = 0; r < kmse_pkg::NUM_ROWS; r++) begin : g_lane
        logic layer;
        // row 7 of column 7 sees the layer key already updated by row 6
        assign layer = (r == kmse_pkg::NUM_ROWS - 1 && column == kmse_pkg::LAST_COLUMN)
                       ? ~sense_bits[kmse_pkg::LAYER_ROW]
                       : map_reg[kmse_pkg::LAYER_ROW][kmse_pkg::LAST_COLUMN];
        kmse_lane u_lane (
            .row_idx  (3'(r)),
            .column   (column),
            .sense    (sense_bits[r]),
            .was_down (map_reg[r][column]),
            .layer    (layer),
            .res      (lanes[r])
        );
    end

    always_comb begin
        any_chg = 1'b0;
        for (int i = 0; i < kmse_pkg::NUM_ROWS; i++) begin
            any_chg = any_chg | lanes[i].chg;
        end
    end

    assign commit = (column == kmse_pkg::LAST_COLUMN) & (scan_changed_reg | any_chg);

    // map and change flag follow every taken request
    always_comb begin
        map_next          = map_reg;
        scan_changed_next = scan_changed_reg;
        if (s_accept) begin
            for (int i = 0; i < kmse_pkg::NUM_ROWS; i++) begin
                map_next[i][column] = lanes[i].down;
            end
            scan_changed_next = (column == kmse_pkg::LAST_COLUMN)
                                ? 1'b0 : (scan_changed_reg | any_chg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < kmse_pkg::NUM_ROWS; i++) begin
                map_reg[i] <= '0;
            end
            scan_changed_reg <= 1'b0;
        end else begin
            map_reg          <= map_next;
            scan_changed_reg <= scan_changed_next;
        end
    end

    kmse_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_load  (s_accept),
        .lanes      (lanes),
        .commit_in  (commit),
        .item_ready (item_ready),
        .m_valid    (m_axis_tvalid),
        .m_kind     (m_kind),
        .m_code     (m_code),
        .m_last     (m_axis_tlast),
        .m_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {6'b0, m_code, m_kind};

    // a commit report never carries a usage code
    a_commit_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == kmse_pkg::EV_COMMIT |-> m_axis_tdata[9:2] == 8'h00)
        else $error("commit event with nonzero usage code");

    // the unused kind code never leaves the block
    a_kind_legal : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("illegal event kind");

    // a column 7 request always closes the scan
    a_scan_close : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && column == kmse_pkg::LAST_COLUMN |=> !scan_changed_reg)
        else $error("change flag survived end of scan");

    // the layer row of the map only moves when a request is taken
    a_map_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(map_reg[kmse_pkg::LAYER_ROW]))
        else $error("pressed map changed without a request");

endmodule

// ===== verif/kmse_event_scoreboard_pkg.sv =====
package kmse_event_scoreboard_pkg;

    import kmse_pkg::*;

    // key slot per matrix position, index row*8+column
    localparam bit [5:0] KEY_SLOT [64] = '{
        6'd23, 6'd0,  6'd20, 6'd24, 6'd15, 6'd19, 6'd16, 6'd0,
        6'd50, 6'd52, 6'd49, 6'd51, 6'd43, 6'd46, 6'd45, 6'd41,
        6'd36, 6'd27, 6'd48, 6'd39, 6'd30, 6'd33, 6'd44, 6'd28,
        6'd58, 6'd60, 6'd57, 6'd59, 6'd55, 6'd47, 6'd56, 6'd42,
        6'd22, 6'd26, 6'd21, 6'd25, 6'd14, 6'd18, 6'd17, 6'd53,
        6'd37, 6'd40, 6'd35, 6'd38, 6'd31, 6'd34, 6'd32, 6'd29,
        6'd8,  6'd12, 6'd7,  6'd11, 6'd0,  6'd4,  6'd3,  6'd54,
        6'd9,  6'd13, 6'd6,  6'd10, 6'd1,  6'd5,  6'd2,  6'd0
    };

    localparam int unsigned SLOTS_PER_LAYER = 61;

    // hid usage per slot, base layer first, then fn layer
    localparam bit [7:0] HID_CODE [122] = '{
        8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h2D, 8'h2E, 8'h2A, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18,
        8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09,
        8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'hE1, 8'h1D, 8'h1B,
        8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'hE0, 8'h00,
        8'hE2, 8'h2C, 8'hE6, 8'hE7, 8'hE7, 8'hE4,
        8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43,
        8'h44, 8'h45, 8'h4C, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18,
        8'h49, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31, 8'h39, 8'h04, 8'h16, 8'h07, 8'h09,
        8'h0A, 8'h50, 8'h51, 8'h52, 8'h4F, 8'h33, 8'h34, 8'h28, 8'hE1, 8'h1D, 8'h1B,
        8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'hE0, 8'h00,
        8'hE2, 8'h2C, 8'hE6, 8'hE7, 8'hE7, 8'hE4
    };

    typedef struct packed {
        kmse_kind_t kind;
        logic [7:0] code;
        logic       last;
    } key_event_t;

    class kmse_event_scoreboard;
        bit [63:0]   map_down;
        bit          commit_pending;
        bit [1:0]    shift_down;    // bit 0 left, bit 1 right
        key_event_t  pending_events[$];
        int unsigned errors;

        // work out the events one accepted request causes
        function void note_request(input bit [2:0] col, input bit [7:0] sense);
            key_event_t batch[$];
            bit [5:0]   pos;
            bit         now_down;
            bit         layer;
            bit [7:0]   code;
            for (int row = 0; row < NUM_ROWS; row++) begin
                pos      = 6'(row * 8 + int'(col));
                now_down = ~sense[row];
                // layer follows changes made earlier in this same request
                layer    = map_down[{LAYER_ROW, LAST_COLUMN}];
                code     = HID_CODE[int'(layer) * SLOTS_PER_LAYER + int'(KEY_SLOT[pos])];
                if (now_down == map_down[pos])
                    continue;
                commit_pending = 1'b1;
                map_down[pos]  = now_down;
                if (now_down) begin
                    if (code == USAGE_ESC && shift_down != 2'b00)
                        code = USAGE_TILDE;
                    batch.push_back('{EV_PRESS, code, 1'b0});
                end else begin
                    if (code == USAGE_ESC)
                        batch.push_back('{EV_RELEASE, USAGE_TILDE, 1'b0});
                    batch.push_back('{EV_RELEASE, code, 1'b0});
                end
                if (code == USAGE_LSHIFT)
                    shift_down[0] = now_down;
                if (code == USAGE_RSHIFT)
                    shift_down[1] = now_down;
            end
            if (col == LAST_COLUMN) begin
                if (commit_pending)
                    batch.push_back('{EV_COMMIT, 8'h00, 1'b0});
                commit_pending = 1'b0;
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                pending_events.push_back(batch[i]);
        endfunction

        function void check_event(input logic [15:0] data, input logic tlast, input time stamp);
            key_event_t want;
            key_event_t got;
            got.kind = kmse_kind_t'(data[1:0]);
            got.code = data[9:2];
            got.last = tlast;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event kind %0d code %02h last %0b",
                         stamp, got.kind, got.code, got.last);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: event kind expected %0d actual %0d", stamp, want.kind, got.kind);
                errors++;
            end
            if (got.code !== want.code) begin
                $display("%0t: usage code expected %02h actual %02h", stamp, want.code, got.code);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: tlast expected %0b actual %0b", stamp, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== verif/keyboard_matrix_scan_events_tb.sv =====
module keyboard_matrix_scan_events_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kmse_event_scoreboard_pkg::*;

    // no-handshake cycles before the run is declared hung; longest legal gap is the
    // receiver hold-off below plus a few dozen events
    localparam int unsigned STUCK_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 40;

    // idling per phase: none, sender idle, receiver stalling, both
    localparam int unsigned SEND_IDLE  [4] = '{0, 49, 0, 13};
    localparam int unsigned RECV_STALL [4] = '{0, 0, 49, 13};

    // positions that hit the special cases: the four escape slots, both shifts, layer key
    localparam bit [5:0] HOT_KEYS [7] = '{6'd1, 6'd7, 6'd52, 6'd63, 6'd15, 6'd9, 6'd55};

    // directed requests: column and active-low sense lines
    localparam bit [2:0] DIR_COL [25] = '{
        3'd0, 3'd7, 3'd1, 3'd7, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd7, 3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd4, 3'd4, 3'd7, 3'd4, 3'd4, 3'd7
    };
    localparam bit [7:0] DIR_SENSE [25] = '{
        8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hBF, 8'hFF, 8'hFD, 8'hBF, 8'hFF, 8'hFF
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    kmse_event_scoreboard sb = new();

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned stuck_cycles = 0;
    bit [63:0]   held_keys = '0;    // keys held on the virtual keyboard

    keyboard_matrix_scan_events dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side: random stalls, or a long hold-off counted down here
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // handshake monitor: values read here are the ones sampled at this edge, so the
    // request is noted before any event that could follow from it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[2:0], s_axis_tdata[10:3]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_event(m_axis_tdata, m_axis_tlast, $time);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles == STUCK_LIMIT) begin
                    $display("keyboard_matrix_scan_events_tb: errors");
                    $finish;
                end
            end
        end
    end

    // offer one request, with random idle cycles ahead of it, and hold it until taken
    task automatic send_request(input bit [2:0] col, input bit [7:0] sense);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, sense, col};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // sender pauses until every expected event has come out
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_events.size() != 0)
            @(posedge aclk);
    endtask

    // mostly full scans, column 0 to 7, of a keyboard whose keys change a few at a time;
    // the rest is noise: a random column with random or extreme sense lines
    task automatic run_scans(input int n_items);
        int       sent;
        bit [5:0] pos;
        bit [7:0] sense;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                case ($urandom_range(3))
                    0: sense = 8'h00;
                    1: sense = 8'hFF;
                    default: sense = 8'($urandom);
                endcase
                send_request(3'($urandom_range(7)), sense);
                sent++;
            end else begin
                // now and then every key goes up at once
                if ($urandom_range(99) < 5)
                    held_keys = '0;
                repeat ($urandom_range(3, 1)) begin
                    if ($urandom_range(1))
                        pos = HOT_KEYS[$urandom_range(6)];
                    else
                        pos = 6'($urandom_range(63));
                    held_keys[pos] = ~held_keys[pos];
                end
                for (int c = 0; c < 8; c++) begin
                    for (int r = 0; r < 8; r++)
                        sense[r] = ~held_keys[r * 8 + c];
                    send_request(3'(c), sense);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling: idle scans with no events, whole columns pressed
        // and released, escape pressed under right shift while the fn layer comes on,
        // releases in the other layer, escape alone, escape under left shift
        foreach (DIR_COL[i])
            send_request(DIR_COL[i], DIR_SENSE[i]);
        wait_drain();

        // random scans under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = SEND_IDLE[phase];
            recv_stall_pct  = RECV_STALL[phase];
            run_scans(80);
            wait_drain();
        end

        // receiver holds off while scans keep coming, so the block backs up its input
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = HOLD_CYCLES;
        run_scans(24);
        wait_drain();

        // extra cycles catch any event beyond the expected ones
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("keyboard_matrix_scan_events_tb: clean");
        else
            $display("keyboard_matrix_scan_events_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/kmse_pkg.sv
hw/rtl/kmse_lane.sv
hw/rtl/kmse_merge.sv
hw/rtl/keyboard_matrix_scan_events.sv
verif/kmse_event_scoreboard_pkg.sv
verif/keyboard_matrix_scan_events_tb.sv
